// ===== hdl/b64_pkg.sv =====
`default_nettype none

package b64_pkg;

    localparam int B64_QUEUE_DEPTH = 2;

    // job kinds
    localparam logic [1:0] JOB_ENC = 2'd0;
    localparam logic [1:0] JOB_DEC = 2'd1;
    localparam logic [1:0] JOB_ERR = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_LEN  = 2'd1;
    localparam logic [1:0] ST_CHAR = 2'd2;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'

    // one group's worth of results for the back end
    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] bits;
        logic [1:0]  cnt_m1;   // number of results minus one
        logic [1:0]  pads;     // encode: trailing '=' count
        logic        fin;      // last group of the message
        logic [1:0]  status;
    } job_t;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)
            c = 8'h41 + {2'b00, v};
        else if (v < 6'd52)
            c = 8'h61 + {2'b00, v - 6'd26};
        else if (v < 6'd62)
            c = 8'h30 + {2'b00, v - 6'd52};
        else if (v == 6'd62)
            c = CHAR_PLUS;
        else
            c = CHAR_SLASH;
        return c;
    endfunction

    // bit 6 set: character outside the alphabet
    function automatic logic [6:0] char_sextet(input logic [7:0] c);
        logic [6:0] s;
        if (c >= 8'h41 && c <= 8'h5A)
            s = 7'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A)
            s = 7'(c - 8'h61 + 8'd26);
        else if (c >= 8'h30 && c <= 8'h39)
            s = 7'(c - 8'h30 + 8'd52);
        else if (c == CHAR_PLUS)
            s = 7'd62;
        else if (c == CHAR_SLASH)
            s = 7'd63;
        else
            s = 7'd64;
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/base64_codec.sv =====
`default_nettype none

// Base64 codec, alphabet A-Z a-z 0-9 + /. cfg_data selects the direction:
// 0 encodes bytes to text, 1 decodes text to bytes; a write also drops any
// partly gathered group, so write it only while the block is idle. One byte
// or character enters per transaction on s_axis, with tlast marking the end
// of the message. Results leave one per cycle on m_axis while tready is high:
// tdata is the character or byte, tlast marks the last result of the message,
// tuser bit 0 marks the last result caused by one input transaction and
// tuser[2:1] is the status (0 ok, 1 decode message length not a multiple of
// four, 2 character outside the alphabet; an error gives a single zero byte
// that ends the message). The front end takes a transaction every cycle while
// the job queue has room and turns each completed group into one job; the
// back end expands a job into its results at one per cycle while tready is
// high, through a registered output stage. Throughput is therefore set by the
// output: an encode group of three bytes gives four characters, a decode
// group of four characters gives three bytes, so decoding runs at one
// character per cycle. A completing transaction's job passes through the job
// queue and the current-job register before its first result is registered.
module base64_codec
    import b64_pkg::*;
#(
    parameter int QUEUE_DEPTH = B64_QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data,       // direction

    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,   // final_item

    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast,   // message_end
    output logic [2:0]      m_axis_tuser    // [0] run_end, [2:1] status
);

    job_t job;
    job_t head;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    logic run_end;
    logic [1:0] status;

    // configuration is always taken; it sets the direction and clears front-end group state
    assign cfg_ready = 1'b1;

    b64_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_byte   (s_axis_tdata),
        .in_final  (s_axis_tlast),
        .q_full    (q_full),
        .in_ready  (s_axis_tready),
        .push      (push),
        .job       (job)
    );

    b64_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (job),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    b64_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_empty     (q_empty),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_byte    (m_axis_tdata),
        .out_run_end (run_end),
        .out_msg_end (m_axis_tlast),
        .out_status  (status)
    );

    assign m_axis_tuser = {status, run_end};

endmodule

`default_nettype wire

// ===== hdl/b64_front.sv =====
`default_nettype none

module b64_front
    import b64_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    input  wire logic       cfg_data,
    input  wire logic       in_valid,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_final,
    input  wire logic       q_full,
    output logic            in_ready,
    output logic            push,
    output job_t            job
);

    logic        direction_reg, direction_next;
    logic [23:0] group_bits_reg, group_bits_next;
    logic [1:0]  group_pos_reg, group_pos_next;
    logic [1:0]  pad_marks_reg, pad_marks_next;

    logic        accept;
    logic        emit;
    logic [1:0]  pos;
    logic [23:0] base_bits;
    logic [23:0] ins_bits;
    logic [1:0]  pm_base;
    logic [1:0]  pm_new;
    logic [6:0]  sext;
    logic        is_pad;
    logic [5:0]  sv;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && emit;

    always_comb
    begin
        direction_next  = direction_reg;
        group_bits_next = group_bits_reg;
        group_pos_next  = group_pos_reg;
        pad_marks_next  = pad_marks_reg;
        emit      = 1'b0;
        job       = '0;
        pos       = group_pos_reg;
        base_bits = (group_pos_reg == 2'd0) ? 24'd0 : group_bits_reg;
        ins_bits  = '0;
        pm_base   = (group_pos_reg == 2'd0) ? 2'd0 : pad_marks_reg;
        pm_new    = pm_base;
        is_pad    = (in_byte == CHAR_PAD);
        sext      = is_pad ? 7'd0 : char_sextet(in_byte);
        sv        = sext[5:0];

        if (!direction_reg)
        begin
            // encode: three bytes per group
            if (group_pos_reg > 2'd2)
            begin
                pos       = 2'd0;
                base_bits = 24'd0;
            end
            case (pos)
                2'd0:    ins_bits = {in_byte, 16'd0};
                2'd1:    ins_bits = {8'd0, in_byte, 8'd0};
                default: ins_bits = {16'd0, in_byte};
            endcase
            job.kind   = JOB_ENC;
            job.bits   = base_bits | ins_bits;
            job.cnt_m1 = 2'd3;
            job.fin    = in_final;
            job.status = ST_OK;
            unique case (pos)
                2'd0:    job.pads = 2'd2;
                2'd1:    job.pads = 2'd1;
                default: job.pads = 2'd0;
            endcase
            if (pos == 2'd2 || in_final)
            begin
                emit            = 1'b1;
                group_bits_next = '0;
                group_pos_next  = '0;
                pad_marks_next  = '0;
            end
            else
            begin
                group_bits_next = job.bits;
                group_pos_next  = pos + 2'd1;
            end
        end
        else
        begin
            // decode: four characters per group
            case (pos)
                2'd0:    ins_bits = {sv, 18'd0};
                2'd1:    ins_bits = {6'd0, sv, 12'd0};
                2'd2:    ins_bits = {12'd0, sv, 6'd0};
                default: ins_bits = {18'd0, sv};
            endcase
            if (is_pad && pos >= 2'd2)
                pm_new = pm_base + 2'd1;
            job.bits = base_bits | ins_bits;
            job.fin  = in_final;
            job.pads = '0;
            if (sext[6])
            begin
                emit       = 1'b1;
                job.kind   = JOB_ERR;
                job.bits   = '0;
                job.cnt_m1 = 2'd0;
                job.fin    = 1'b1;
                job.status = ST_CHAR;
                group_bits_next = '0;
                group_pos_next  = '0;
                pad_marks_next  = '0;
            end
            else if (pos != 2'd3)
            begin
                if (in_final)
                begin
                    emit       = 1'b1;
                    job.kind   = JOB_ERR;
                    job.bits   = '0;
                    job.cnt_m1 = 2'd0;
                    job.fin    = 1'b1;
                    job.status = ST_LEN;
                    group_bits_next = '0;
                    group_pos_next  = '0;
                    pad_marks_next  = '0;
                end
                else
                begin
                    group_bits_next = job.bits;
                    group_pos_next  = pos + 2'd1;
                    pad_marks_next  = pm_new;
                end
            end
            else
            begin
                emit       = 1'b1;
                job.kind   = JOB_DEC;
                job.status = ST_OK;
                // final group drops one byte per trailing '='
                if (in_final)
                    job.cnt_m1 = (pm_new > 2'd2) ? 2'd0 : 2'd2 - pm_new;
                else
                    job.cnt_m1 = 2'd2;
                group_bits_next = '0;
                group_pos_next  = '0;
                pad_marks_next  = '0;
            end
        end

        if (cfg_valid)
        begin
            direction_next  = cfg_data;
            group_bits_next = '0;
            group_pos_next  = '0;
            pad_marks_next  = '0;
        end
        else if (!accept)
        begin
            group_bits_next = group_bits_reg;
            group_pos_next  = group_pos_reg;
            pad_marks_next  = pad_marks_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg  <= 1'b0;
            group_bits_reg <= '0;
            group_pos_reg  <= '0;
            pad_marks_reg  <= '0;
        end
        else
        begin
            direction_reg  <= direction_next;
            group_bits_reg <= group_bits_next;
            group_pos_reg  <= group_pos_next;
            pad_marks_reg  <= pad_marks_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/b64_fifo.sv =====
`default_nettype none

module b64_fifo
    import b64_pkg::*;
#(
    parameter int DEPTH = B64_QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head,
    output logic      full,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/b64_back.sv =====
`default_nettype none

module b64_back
    import b64_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire job_t       head,
    input  wire logic       q_empty,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            out_run_end,
    output logic            out_msg_end,
    output logic [1:0]      out_status
);

    job_t        cur_reg;
    logic        cur_valid_reg, cur_valid_next;
    logic [1:0]  idx_reg, idx_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        out_run_reg;
    logic        out_msg_reg;
    logic [1:0]  out_status_reg;

    logic        load;
    logic        cur_last;
    logic [5:0]  sextet;
    logic [7:0]  res_byte;

    assign load     = cur_valid_reg && (!out_valid_reg || out_ready);
    assign cur_last = (idx_reg == cur_reg.cnt_m1);
    assign pop      = !q_empty && (!cur_valid_reg || (load && cur_last));

    always_comb
    begin
        sextet   = '0;
        res_byte = '0;
        case (idx_reg)
            2'd0:    sextet = cur_reg.bits[23:18];
            2'd1:    sextet = cur_reg.bits[17:12];
            2'd2:    sextet = cur_reg.bits[11:6];
            default: sextet = cur_reg.bits[5:0];
        endcase
        unique case (cur_reg.kind)
            JOB_ENC:
            begin
                if ({1'b0, idx_reg} + {1'b0, cur_reg.pads} >= 3'd4)
                    res_byte = CHAR_PAD;
                else
                    res_byte = sextet_char(sextet);
            end
            JOB_DEC:
            begin
                case (idx_reg)
                    2'd0:    res_byte = cur_reg.bits[23:16];
                    2'd1:    res_byte = cur_reg.bits[15:8];
                    default: res_byte = cur_reg.bits[7:0];
                endcase
            end
            default: res_byte = '0;
        endcase
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            idx_next = idx_reg + 2'd1;
            if (cur_last)
                cur_valid_next = 1'b0;
        end
        if (pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end

        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head;
        if (load)
        begin
            out_byte_reg   <= res_byte;
            out_run_reg    <= cur_last;
            out_msg_reg    <= cur_last && cur_reg.fin;
            out_status_reg <= cur_reg.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign out_run_end = out_run_reg;
    assign out_msg_end = out_msg_reg;
    assign out_status  = out_status_reg;

    // end of message is always end of a run
    a_msg_implies_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_msg_reg |-> out_run_reg)
        else $error("message end without run end");

    // error results are single zero bytes closing the message
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != ST_OK |->
            out_byte_reg == 8'd0 && out_run_reg && out_msg_reg)
        else $error("malformed error result");

    // the result index never passes the job's last result
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> idx_reg <= cur_reg.cnt_m1)
        else $error("result index beyond job");

endmodule

`default_nettype wire
